### src/rolling_sum_chunk_splitter_core_assert.svh
// Assertion macros for the chunk splitter RTL
`ifndef ROLLING_SUM_CHUNK_SPLITTER_CORE_ASSERT_SVH
`define ROLLING_SUM_CHUNK_SPLITTER_CORE_ASSERT_SVH

// same-cycle implication
`define RSSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rssc_pkg.sv
// Types, constants and register codes of the rolling-sum chunk splitter
package rssc_pkg;

  localparam int WINDOW_SIZE = 64;
  localparam int CHAR_OFFSET = 31;

  localparam int BYTE_W    = 8;
  localparam int SUM_W     = 32;
  localparam int LEN_W     = 21;
  localparam int SB_W      = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = LEN_W;

  // signed byte difference and the per-item correction term
  localparam int DIFF_W = BYTE_W + 1;
  localparam int KMAX   = WINDOW_SIZE * (255 + CHAR_OFFSET) + 255;
  localparam int EXT_W  = $clog2(KMAX + 1) + 1;

  localparam logic [SUM_W-1:0] SUM_ONE_RST = SUM_W'(WINDOW_SIZE * CHAR_OFFSET);
  localparam logic [SUM_W-1:0] SUM_TWO_RST =
    SUM_W'(WINDOW_SIZE * (WINDOW_SIZE - 1) * CHAR_OFFSET);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_BITS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = CFG_IDX_W'(2);

  localparam logic [SB_W-1:0] SPLIT_BITS_RST = SB_W'(17);
  localparam len_t            MIN_LEN_RST    = LEN_W'(64 << 10);
  localparam len_t            MAX_LEN_RST    = LEN_W'(1 << 20);

  typedef struct packed {
    logic [SB_W-1:0] split_bits;
    len_t            min_len;
    len_t            max_len;
  } cfg_t;

  typedef struct packed {
    logic valid;
    sum_t sum_two;
  } roll_t;

endpackage

### src/rssc_if.sv
// Channel interfaces: byte input, result output, configuration writes
interface rssc_in_if;
  import rssc_pkg::*;
  logic  valid;
  logic  ready;
  byte_t data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rssc_out_if;
  import rssc_pkg::*;
  logic valid;
  logic ready;
  logic split;
  len_t chunk_len;
  modport source (output valid, output split, output chunk_len, input ready);
  modport sink (input valid, input split, input chunk_len, output ready);
endinterface

interface rssc_cfg_if;
  import rssc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/rssc_cell.sv
// One window cell: holds a byte and passes it on as each item enters
module rssc_cell
  import rssc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  shift_en,
  input  byte_t byte_in,
  output byte_t byte_out
);

  byte_t byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

### src/rssc_roll.sv
// Rolling sums: difference stage, then sum_one / sum_two update stage
module rssc_roll
  import rssc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  input  byte_t drop_byte,
  output roll_t roll_o,
  input  logic  roll_ready
);

  logic                     a_valid_r;
  logic signed [DIFF_W-1:0] a_diff_r;
  logic signed [EXT_W-1:0]  a_ext_r;
  logic                     b_valid_r;
  sum_t                     s1_r;
  sum_t                     s2_r;

  logic                     a_ready;
  logic                     b_ready;
  logic signed [DIFF_W-1:0] diff;
  logic [EXT_W-2:0]         kprod;
  logic signed [EXT_W-1:0]  ext;
  sum_t                     s1_nxt;
  sum_t                     s2_nxt;

  assign b_ready  = !b_valid_r || roll_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_comb begin
    diff  = $signed({1'b0, in_byte}) - $signed({1'b0, drop_byte});
    kprod = (EXT_W-1)'(WINDOW_SIZE) *
            ((EXT_W-1)'(drop_byte) + (EXT_W-1)'(CHAR_OFFSET));
    ext   = EXT_W'(diff) - $signed({1'b0, kprod});
  end

  always_comb begin
    s1_nxt = s1_r + SUM_W'(a_diff_r);
    s2_nxt = s2_r + s1_r + SUM_W'(a_ext_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      s1_r      <= SUM_ONE_RST;
      s2_r      <= SUM_TWO_RST;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (a_valid_r && b_ready) begin
        s1_r <= s1_nxt;
        s2_r <= s2_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_diff_r <= diff;
      a_ext_r  <= ext;
    end
  end

  assign roll_o.valid   = b_valid_r;
  assign roll_o.sum_two = s2_r;

endmodule

### src/rssc_cut.sv
// Chunk length counter, split decision and result register
module rssc_cut
  import rssc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  roll_t roll_i,
  output logic  roll_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output logic  out_split,
  output len_t  out_len
);

`include "rolling_sum_chunk_splitter_core_assert.svh"

  logic out_valid_r;
  logic out_split_r;
  len_t out_len_r;
  len_t len_r;

  logic c_ready;
  logic take;
  len_t len1;
  sum_t mask;
  logic on_split;
  logic fire;

  assign c_ready    = !out_valid_r || out_ready;
  assign take       = roll_i.valid && c_ready;
  assign roll_ready = c_ready;

  always_comb begin
    len1     = len_r + LEN_W'(1);
    mask     = ~({SUM_W{1'b1}} << cfg.split_bits);
    on_split = &(roll_i.sum_two | ~mask);
    fire     = (len1 >= cfg.max_len) || (on_split && (len1 > cfg.min_len));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      len_r       <= '0;
    end else begin
      if (c_ready) begin
        out_valid_r <= roll_i.valid;
      end
      if (take) begin
        len_r <= fire ? '0 : len1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_split_r <= fire;
      out_len_r   <= fire ? len1 : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_split = out_split_r;
  assign out_len   = out_len_r;

  `RSSC_ASSERT_NEXT(a_len_clear, clk, rst_n, take && fire, len_r == '0, "count not cleared")
  `RSSC_ASSERT_NOW(a_no_split_zero, clk, rst_n, out_valid_r && !out_split_r, out_len_r == '0, "length without split")
  `RSSC_ASSERT_NOW(a_split_len, clk, rst_n, out_valid_r && out_split_r, out_len_r != '0, "split of empty chunk")

endmodule

### src/rolling_sum_chunk_splitter_core.sv
// Top level of the rolling-sum content-defined chunk splitter
//
//   channel  | dir | handshake    | payload
//   in_item  | in  | valid/ready  | data_byte[7:0]
//   out_item | out | valid/ready  | split, chunk_len[20:0]
//   cfg_wr   | in  | valid/ready  | index[1:0], data[20:0]
//
// One item per cycle sustained while out_item is ready; output is registered.
// The sum_two update and the length counter each feed back on their register.
// Reset (synchronous) clears the window cells, presets the sums, zeroes the
// count and loads the register defaults; cfg_wr is always ready.
// Each stage holds while the one after it is full and stalled; in_item stalls
// only when all three stages hold items.
module rolling_sum_chunk_splitter_core
  import rssc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  rssc_in_if.sink      in_item,
  rssc_out_if.source   out_item,
  rssc_cfg_if.sink     cfg_wr
);

  cfg_t  cfg_r;
  byte_t tap [WINDOW_SIZE];
  logic  in_ready;
  logic  shift_en;
  roll_t roll;
  logic  roll_ready;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.split_bits <= SPLIT_BITS_RST;
      cfg_r.min_len    <= MIN_LEN_RST;
      cfg_r.max_len    <= MAX_LEN_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_SPLIT_BITS: cfg_r.split_bits <= cfg_wr.data[SB_W-1:0];
        REG_MIN_LEN:    cfg_r.min_len    <= cfg_wr.data;
        REG_MAX_LEN:    cfg_r.max_len    <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign in_item.ready = in_ready;
  assign shift_en      = in_item.valid && in_ready;

  // window as a row of cells; the last cell holds the byte that leaves
  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    if (i == 0) begin : g_head
      rssc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .byte_in  (in_item.data_byte),
        .byte_out (tap[i])
      );
    end else begin : g_body
      rssc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .byte_in  (tap[i-1]),
        .byte_out (tap[i])
      );
    end
  end

  rssc_roll u_roll (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_item.valid),
    .in_ready   (in_ready),
    .in_byte    (in_item.data_byte),
    .drop_byte  (tap[WINDOW_SIZE-1]),
    .roll_o     (roll),
    .roll_ready (roll_ready)
  );

  rssc_cut u_cut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .roll_i     (roll),
    .roll_ready (roll_ready),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .out_split  (out_item.split),
    .out_len    (out_item.chunk_len)
  );

endmodule
